FILE: design/gb5_pkg.sv
// Shared types and constants for the 5x5 binomial blur core.
package gb5_pkg;

  localparam int PIX_W         = 8;
  localparam int LINES         = 4;
  localparam int WIN           = 5;
  localparam int DEF_MAX_WIDTH = 512;

  localparam int IMG_W_W    = 10;
  localparam int IMG_H_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int CMP_W      = 13;

  localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(320);
  localparam logic [IMG_H_W-1:0] IMG_H_RESET = IMG_H_W'(320);
  localparam logic [CMP_W-1:0]   MIN_DIM     = CMP_W'(5);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Column sum of 1,4,6,4,1 over 8-bit pixels is at most 4080.
  localparam int VSUM_W   = 12;
  localparam int WEIGHT_W = 3;
  // Full weighted sum is at most 255 * 256 = 65280.
  localparam int PSUM_W   = 16;

  localparam logic [WEIGHT_W-1:0] TAP_WEIGHT [WIN] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] filtered_pixel;
    logic             frame_last;
  } res_t;

endpackage

FILE: design/gaussian_blur_5x5_core.sv
// Top level of the 5x5 binomial blur core: position tracking, line store and cell chain.
//
// Pixels arrive in raster order on the in channel (in_valid / in_ready / pixel). Once the
// current pixel is at least four rows and four columns into the frame, the item yields one
// result on the out channel (out_valid / out_ready / filtered_pixel / frame_last); earlier
// pixels yield nothing, so the output frame is (width-4) x (height-4).
// Registers image_width (index 0) and image_height (index 1) are written on the cfg channel,
// which is always ready; write them only while the core is idle.
// One pixel is taken every cycle while in_ready is high. After its pixel is taken, a result
// passes through the line store read, the shift of the column sum into the cell chain and
// the addition of the five weighted columns into the output queue.
// The output queue holds four results; when the receiver stalls the queue fills and
// in_ready drops only once queue and pipeline together hold four items.
// After reset the line store is cleared one column per cycle, across all MAX_WIDTH columns,
// while in_ready stays low; configuration writes are taken throughout. Reset also sets
// both dimensions to 320 and the positions to the frame start.
module gaussian_blur_5x5_core
  import gb5_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      filtered_pixel,
  output logic                  frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [CMP_W-1:0] MAX_W_C  = CMP_W'(MAX_WIDTH);
  localparam logic [PW-1:0]    LAST_COL = PW'(MAX_WIDTH - 1);
  localparam logic [CMP_W-1:0] EDGE_POS = CMP_W'(WIN - 1);

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [PW-1:0]      col_pos;
  logic [IMG_H_W-1:0] row_pos;
  logic               clr_active;
  logic [PW-1:0]      clr_addr;

  logic [CMP_W-1:0] w_use;
  logic [CMP_W-1:0] h_use;
  logic [PW-1:0]    c_cur;
  logic             row_end;
  logic             frame_end;
  logic             produce;
  logic             accept;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_px;
  logic [PW-1:0]    s1_col;
  logic             s1_prod;
  logic             s1_last;
  logic             s2_valid;
  logic             s2_prod;
  logic             s2_last;

  logic [LINES*PIX_W-1:0] lb_rd_data;
  logic [LINES*PIX_W-1:0] lb_wr_data;
  logic [PW-1:0]          lb_wr_addr;
  logic                   lb_wr_en;
  logic [VSUM_W-1:0]      vsum;

  logic [VSUM_W-1:0] chain_col  [WIN+1];
  logic [PSUM_W-1:0] chain_psum [WIN+1];

  res_t                   res;
  res_t                   head;
  logic [OFIFO_CNT_W-1:0] q_count;
  logic [OFIFO_CNT_W:0]   occupancy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_RESET;
      image_height <= IMG_H_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Width in use is clamped to the range the line store supports, height to at least five.
  always_comb begin
    w_use = CMP_W'(image_width);
    if (w_use < MIN_DIM) begin
      w_use = MIN_DIM;
    end else if (w_use > MAX_W_C) begin
      w_use = MAX_W_C;
    end
    h_use = CMP_W'(image_height);
    if (h_use < MIN_DIM) begin
      h_use = MIN_DIM;
    end
  end

  assign c_cur     = (CMP_W'(col_pos) >= MAX_W_C) ? '0 : col_pos;
  assign row_end   = (CMP_W'(c_cur) + CMP_W'(1)) >= w_use;
  assign frame_end = row_end && ((CMP_W'(row_pos) + CMP_W'(1)) >= h_use);
  assign produce   = (CMP_W'(row_pos) >= EDGE_POS) && (CMP_W'(c_cur) >= EDGE_POS);

  // Queue space is reserved for every item in flight, so the pipeline never has to stall.
  assign occupancy = (OFIFO_CNT_W+1)'(q_count) + (OFIFO_CNT_W+1)'(s1_valid)
                   + (OFIFO_CNT_W+1)'(s2_valid);
  assign in_ready  = !clr_active && (occupancy < (OFIFO_CNT_W+1)'(OFIFO_DEPTH));
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_pos    <= '0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + PW'(1);
        if (clr_addr == LAST_COL) begin
          clr_active <= 1'b0;
        end
      end
      if (accept) begin
        if (row_end) begin
          col_pos <= '0;
          row_pos <= frame_end ? '0 : row_pos + IMG_H_W'(1);
        end else begin
          col_pos <= c_cur + PW'(1);
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= pixel;
      s1_col  <= c_cur;
      s1_prod <= produce;
      s1_last <= frame_end;
    end
    if (s1_valid) begin
      s2_prod <= s1_prod;
      s2_last <= s1_last;
    end
  end

  // The column moves up one row: the oldest line drops out and the new pixel goes on top.
  assign lb_wr_en   = clr_active || s1_valid;
  assign lb_wr_addr = clr_active ? clr_addr : s1_col;
  assign lb_wr_data = clr_active ? '0 : {s1_px, lb_rd_data[LINES*PIX_W-1:PIX_W]};

  gb5_linebuf #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (PW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c_cur),
    .rd_data (lb_rd_data),
    .wr_en   (lb_wr_en),
    .wr_addr (lb_wr_addr),
    .wr_data (lb_wr_data)
  );

  // Vertical 1,4,6,4,1 sum of the new column, oldest line first.
  always_comb begin
    logic [VSUM_W-1:0] p0, p1, p2, p3, p4;
    p0 = VSUM_W'(lb_rd_data[PIX_W-1:0]);
    p1 = VSUM_W'(lb_rd_data[2*PIX_W-1:PIX_W]);
    p2 = VSUM_W'(lb_rd_data[3*PIX_W-1:2*PIX_W]);
    p3 = VSUM_W'(lb_rd_data[4*PIX_W-1:3*PIX_W]);
    p4 = VSUM_W'(s1_px);
    vsum = p0 + (p1 << 2) + (p2 << 2) + (p2 << 1) + (p3 << 2) + p4;
  end

  assign chain_col[0]  = vsum;
  assign chain_psum[0] = '0;

  for (genvar g = 0; g < WIN; g++) begin : g_cell
    gb5_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (s1_valid),
      .col_in   (chain_col[g]),
      .weight   (TAP_WEIGHT[g]),
      .psum_in  (chain_psum[g]),
      .col_out  (chain_col[g+1]),
      .psum_out (chain_psum[g+1])
    );
  end

  // The full sum stays below 65536, so taking the top byte already saturates at 255.
  assign res.filtered_pixel = chain_psum[WIN][PSUM_W-1:PSUM_W-PIX_W];
  assign res.frame_last     = s2_last;

  gb5_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid && s2_prod),
    .push_data (res),
    .pop       (out_valid && out_ready),
    .head      (head),
    .count     (q_count)
  );

  assign out_valid      = (q_count != '0);
  assign filtered_pixel = head.filtered_pixel;
  assign frame_last     = head.frame_last;

endmodule

FILE: design/gb5_cell.sv
// One window column: holds its vertical sum and adds its weighted share to the running sum.
module gb5_cell
  import gb5_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [VSUM_W-1:0]   col_in,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [PSUM_W-1:0]   psum_in,
  output logic [VSUM_W-1:0]   col_out,
  output logic [PSUM_W-1:0]   psum_out
);

  logic [VSUM_W-1:0] col_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_sum <= '0;
    end else if (shift) begin
      col_sum <= col_in;
    end
  end

  assign col_out  = col_sum;
  // The product of a column sum and the centre weight needs 15 bits, so widen before multiplying.
  assign psum_out = psum_in + PSUM_W'(col_sum) * PSUM_W'(weight);

endmodule

FILE: design/gb5_linebuf.sv
// Line store: four previous rows packed in one word per column, registered read.
module gb5_linebuf
  import gb5_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int ADDR_W    = 9
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [LINES*PIX_W-1:0]   rd_data,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [LINES*PIX_W-1:0]   wr_data
);

  logic [LINES*PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/gb5_ofifo.sv
// Small output queue that decouples the result stream from the pipeline.
module gb5_ofifo
  import gb5_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  res_t                   push_data,
  input  logic                   pop,
  output res_t                   head,
  output logic [OFIFO_CNT_W-1:0] count
);

  res_t                   entry [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_ptr;
  logic [OFIFO_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OFIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OFIFO_PTR_W'(1);
      end
      count <= count + OFIFO_CNT_W'(push) - OFIFO_CNT_W'(pop);
    end
  end

  assign head = entry[rd_ptr];

endmodule
